// ===== hw/rtl/llcc_pkg.sv =====
// Shared constants for the laser line column centroid core.
package llcc_pkg;

	localparam int PIX_W      = 8;
	localparam int CH_W       = 11;
	localparam int POS_W      = 18;
	localparam int PEAK_ROW_W = 10;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [CH_W-1:0]  CH_RESET = 11'd480;
	localparam logic [POS_W-1:0] POS_MAX  = 18'h3FFFF;

	// Register word index, taken from paddr[2]
	localparam logic REG_COLUMN_HEIGHT = 1'b0;

endpackage

// ===== hw/rtl/llcc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module llcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/laser_line_column_centroid_core.sv =====
// Laser line column centroid core: column store, peak tracking, window centroid.
//
//  channel   dir  handshake            payload
//  -------   ---  -------------------  -------------------------------------------------
//  pixel     in   pix_valid/pix_stall  pixel_value[7:0], end_of_column
//  result    out  res_valid/res_stall  line_found, line_position[17:0], peak_row[9:0],
//                                      peak_value[7:0], window_clipped
//  config    in   APB (psel/penable)   column_height[10:0] at byte address 0
//
//  Pixels transfer at one per cycle while pix_stall is low. After the last pixel
//  of a column the core reads 2*HALF_WINDOW rows back out of the column store (one
//  per cycle, one RAM read port), then runs a restoring divider, one quotient bit
//  per cycle: a column with a full window holds the pixel side through the scan,
//  drain, load, divide and done states; no line or a clipped window goes straight to done.
//  Reset clears the row counter, running maximum and FSM; the column store is
//  never cleared, since only rows of the current column are read.
//  A stalled result waits in the output register; the next column's pixels keep
//  transferring, and only the next column's result waits in done for it to go.
module laser_line_column_centroid_core
	import llcc_pkg::*;
#(
	parameter int MAX_ROWS    = 1024,
	parameter int HALF_WINDOW = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// pixel channel
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  logic [PIX_W-1:0]      pixel_value,
	input  logic                  end_of_column,
	// result channel
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic                  line_found,
	output logic [POS_W-1:0]      line_position,
	output logic [PEAK_ROW_W-1:0] peak_row,
	output logic [PIX_W-1:0]      peak_value,
	output logic                  window_clipped,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready
);

	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int WIN    = 2 * HALF_WINDOW;
	localparam int K_W    = $clog2(WIN);
	localparam int Q_W    = K_W + 8;                 // quotient < 256 * WIN
	localparam int CNT_W  = $clog2(Q_W);
	localparam int DEN_W  = $clog2(255 * WIN + 1);
	localparam int NUM_W  = $clog2(255 * HALF_WINDOW * (WIN - 1) + 1);
	localparam int PROD_W = K_W + PIX_W;
	localparam int LIM_W  = (ROW_W + 1 > CH_W) ? ROW_W + 1 : CH_W;
	localparam int PW_A   = (ROW_W + 9 > Q_W + 1) ? ROW_W + 9 : Q_W + 1;
	localparam int PW     = (PW_A > POS_W + 1) ? PW_A : POS_W + 1;

	typedef enum logic [2:0] {
		S_PIXEL,
		S_SCAN,
		S_DRAIN,
		S_LOAD,
		S_DIV,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [CH_W-1:0]     column_height_q;
	logic [ROW_W-1:0]    row_q;
	logic [PIX_W-1:0]    best_v_q;
	logic [ROW_W-1:0]    best_r_q;
	logic [ROW_W-1:0]    peak_q;
	logic [PIX_W-1:0]    peak_v_q;
	logic [ROW_W-1:0]    base_q;
	logic                found_q;
	logic                clipped_q;
	logic [K_W-1:0]      k_q;
	logic [K_W-1:0]      k_s1;
	logic                rd_vld_s1;
	logic [NUM_W-1:0]    num_q;
	logic [DEN_W-1:0]    den_q;
	logic [DEN_W-1:0]    rem_q;
	logic [Q_W-1:0]      quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                res_valid_q;

	logic                pix_xfer;
	logic                cfg_wr;
	logic                upd;
	logic [PIX_W-1:0]    nb_v;
	logic [ROW_W-1:0]    nb_r;
	logic [LIM_W-1:0]    ch_w;
	logic [LIM_W-1:0]    lim_w;
	logic [LIM_W-1:0]    height_w;
	logic                col_last;
	logic                fit;
	logic [PW-1:0]       base_w;
	logic [PW-1:0]       raddr_w;
	logic [ROW_W-1:0]    raddr;
	logic [PIX_W-1:0]    rd_data;
	logic [PROD_W-1:0]   prod;
	logic [DEN_W:0]      trial;
	logic                ge;
	logic [DEN_W:0]      diff;
	logic [PW-1:0]       pos_raw;
	logic [POS_W-1:0]    pos_sat;
	logic                res_free;

	// Configuration: pready tied high, one register at word 0
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_COLUMN_HEIGHT) ? APB_DW'(column_height_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_height_q <= CH_RESET;
		end else if (cfg_wr && paddr[2] == REG_COLUMN_HEIGHT) begin
			column_height_q <= pwdata[CH_W-1:0];
		end
	end

	// Pixel side accepts only while collecting a column
	assign pix_stall = (state_q != S_PIXEL);
	assign pix_xfer  = pix_valid && !pix_stall;

	// Running maximum: first row with the strictly greatest value wins
	assign upd  = pixel_value > best_v_q;
	assign nb_v = upd ? pixel_value : best_v_q;
	assign nb_r = upd ? row_q : best_r_q;

	// Row limit is column_height clamped to 1..MAX_ROWS
	assign ch_w     = LIM_W'(column_height_q);
	assign lim_w    = (ch_w == '0) ? LIM_W'(1) :
	                  (ch_w > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS) : ch_w;
	assign height_w = LIM_W'(row_q) + LIM_W'(1);
	assign col_last = end_of_column || !(height_w < lim_w);

	// Window fits when peak >= HW and peak + HW <= height
	assign fit    = (PW'(nb_r) >= PW'(HALF_WINDOW)) &&
	                (PW'(nb_r) + PW'(HALF_WINDOW) <= PW'(height_w));
	assign base_w = PW'(nb_r) - PW'(HALF_WINDOW);

	// Window read address, stays inside the column when the window fits
	assign raddr_w = PW'(base_q) + PW'(k_q);
	assign raddr   = raddr_w[ROW_W-1:0];

	llcc_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_ROWS)
	) u_column_store (
		.clk   (clk),
		.we    (pix_xfer),
		.waddr (row_q),
		.wdata (pixel_value),
		.raddr (raddr),
		.rdata (rd_data)
	);

	assign prod = PROD_W'(k_s1) * PROD_W'(rd_data);

	// One restoring division step
	assign trial = {rem_q, quo_q[Q_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	// Final position: base * 256 + fraction, or peak row * 256 when clipped; zero with no line, saturated at POS_MAX
	assign pos_raw = clipped_q ? (PW'(peak_q) << 8) : ((PW'(base_q) << 8) + PW'(quo_q));
	assign pos_sat = !found_q ? '0 :
	                 (pos_raw > PW'(POS_MAX)) ? POS_MAX : pos_raw[POS_W-1:0];

	assign res_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_PIXEL;
			row_q          <= '0;
			best_v_q       <= '0;
			best_r_q       <= '0;
			peak_q         <= '0;
			peak_v_q       <= '0;
			base_q         <= '0;
			found_q        <= 1'b0;
			clipped_q      <= 1'b0;
			k_q            <= '0;
			k_s1           <= '0;
			rd_vld_s1      <= 1'b0;
			num_q          <= '0;
			den_q          <= '0;
			rem_q          <= '0;
			quo_q          <= '0;
			cnt_q          <= '0;
			res_valid_q    <= 1'b0;
			line_found     <= 1'b0;
			line_position  <= '0;
			peak_row       <= '0;
			peak_value     <= '0;
			window_clipped <= 1'b0;
		end else begin
			// Raise valid for a finished column, drop it once the result transfers
			if (state_q == S_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end

			// Read pipeline: accumulate weighted and plain sums one row a cycle
			rd_vld_s1 <= (state_q == S_SCAN);
			k_s1      <= k_q;
			if (rd_vld_s1) begin
				num_q <= num_q + NUM_W'(prod);
				den_q <= den_q + DEN_W'(rd_data);
			end

			case (state_q)
				S_PIXEL: begin
					if (pix_xfer) begin
						if (col_last) begin
							peak_q     <= nb_r;
							peak_v_q   <= nb_v;
							base_q     <= base_w[ROW_W-1:0];
							found_q    <= (nb_r != '0);
							clipped_q  <= (nb_r != '0) && !fit;
							row_q      <= '0;
							best_v_q   <= '0;
							best_r_q   <= '0;
							k_q        <= '0;
							num_q      <= '0;
							den_q      <= '0;
							state_q    <= ((nb_r != '0) && fit) ? S_SCAN : S_DONE;
						end else begin
							row_q    <= row_q + ROW_W'(1);
							best_v_q <= nb_v;
							best_r_q <= nb_r;
						end
					end
				end
				S_SCAN: begin
					if (k_q == K_W'(WIN - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + K_W'(1);
					end
				end
				S_DRAIN: begin
					// last window row lands in the sums at this edge
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					// dividend is num * 256; its top bits already lie below den
					rem_q   <= DEN_W'(num_q >> K_W);
					quo_q   <= {num_q[K_W-1:0], 8'h00};
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
					quo_q <= {quo_q[Q_W-2:0], ge};
					if (cnt_q == CNT_W'(Q_W - 1)) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_DONE: begin
					// Hold until the output register is free
					if (res_free) begin
						line_found     <= found_q;
						line_position  <= pos_sat;
						peak_row       <= PEAK_ROW_W'(peak_q);
						peak_value     <= peak_v_q;
						window_clipped <= clipped_q;
						state_q        <= S_PIXEL;
					end
				end
				default: begin
					state_q <= S_PIXEL;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;

	// The divider never sees a zero divisor: the window holds the peak
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (den_q != '0))
		else $error("divisor is zero during division");

	// A column end closes the pixel side on the next cycle
	a_eoc_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_xfer && end_of_column) |=> pix_stall)
		else $error("pixel side open after column end");

	// No line means no position and no clip flag
	a_no_line: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !line_found) |->
		(line_position == '0 && peak_row == '0 && !window_clipped))
		else $error("result without line carries a position");

	// Row counter stays inside the column store
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		PW'(row_q) < PW'(MAX_ROWS))
		else $error("row counter beyond column store");

	// Window reads only happen while the pixel side is closed
	a_scan_closed: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> pix_stall)
		else $error("window read overlaps pixel transfer");

endmodule
